// File: rtl/cmbe_pkg.sv
package cmbe_pkg;

    localparam int MASK_W      = 64;
    localparam int CNT_W       = 7;
    localparam int POS_W       = 6;
    localparam int CHUNK_W     = 16;
    localparam int NUM_CHUNKS  = MASK_W / CHUNK_W;
    localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
    localparam int LOC_W       = $clog2(CHUNK_W);
    localparam int POP_W       = LOC_W + 1;

    // configuration register indexes
    localparam logic REG_TOTAL_COUNT  = 1'b0;
    localparam logic REG_CHOOSE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_EXHAUSTED  = 2'd1,
        STATUS_BAD_CONFIG = 2'd2
    } status_t;

    typedef struct packed {
        logic    load_first;
        logic    scan_start;
        logic    scan_step;
        logic    apply;
        logic    resp_load;
        status_t resp_status;
    } dp_cmd_t;

    typedef struct packed {
        logic cfg_bad;
        logic pivot_found;
        logic last_chunk;
        logic out_free;
    } dp_sts_t;

    // ones in the x lowest bits, all ones when x reaches the mask width
    function automatic logic [MASK_W-1:0] low_mask(input logic [CNT_W-1:0] x);
        return ~({MASK_W{1'b1}} << x);
    endfunction

    function automatic logic [LOC_W-1:0] top_bit(input logic [CHUNK_W-1:0] v);
        logic [LOC_W-1:0] r;
        r = '0;
        for (int i = 0; i < CHUNK_W; i++) begin
            if (v[i]) begin
                r = LOC_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [POP_W-1:0] pop_chunk(input logic [CHUNK_W-1:0] v);
        logic [POP_W-1:0] r;
        r = '0;
        for (int i = 0; i < CHUNK_W; i++) begin
            r = r + POP_W'(v[i]);
        end
        return r;
    endfunction

    // bits strictly above position b
    function automatic logic [CHUNK_W-1:0] above_mask(input logic [LOC_W-1:0] b);
        logic [CHUNK_W-1:0] m;
        m = '0;
        for (int i = 0; i < CHUNK_W; i++) begin
            m[i] = (i > int'(b));
        end
        return m;
    endfunction

endpackage

// File: rtl/cmbe_dp.sv
module cmbe_dp #(
    parameter int MAX_POSITIONS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic                                cfg_addr,
    input  logic [cmbe_pkg::CNT_W-1:0]          cfg_wdata,
    input  cmbe_pkg::dp_cmd_t                   cmd,
    output cmbe_pkg::dp_sts_t                   sts,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [cmbe_pkg::MASK_W-1:0]         m_tdata,
    output logic                                m_tlast,
    output logic [1:0]                          m_tuser
);
    import cmbe_pkg::*;

    logic [CNT_W-1:0]       n_reg;
    logic [CNT_W-1:0]       k_reg;
    logic [MASK_W-1:0]      mask_reg;
    logic [CHUNK_IDX_W-1:0] chunk_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [POS_W-1:0]       pivot_reg;
    logic                   out_valid_reg;
    logic [MASK_W-1:0]      out_mask_reg;
    logic                   out_last_reg;
    status_t                out_status_reg;

    logic [MASK_W-1:0]      full_mask;
    logic [MASK_W-1:0]      above_n;
    logic [MASK_W-1:0]      pivot_cand;
    logic [POS_W-1:0]       chunk_base;
    logic [CHUNK_W-1:0]     cand_chunk;
    logic [CHUNK_W-1:0]     mask_chunk;
    logic                   found;
    logic [LOC_W-1:0]       loc;
    logic [POP_W-1:0]       cnt_add;
    logic [CNT_W-1:0]       cnt_sum;
    logic [CNT_W-1:0]       pivot_ext;
    logic [MASK_W-1:0]      mask_next;
    logic [MASK_W-1:0]      last_mask;
    logic                   out_free;

    // a pivot is a chosen bit whose upper neighbour is free (bits from n up count as taken)
    assign full_mask  = low_mask(n_reg);
    assign above_n    = mask_reg | ~full_mask;
    assign pivot_cand = mask_reg & ~{1'b1, above_n[MASK_W-1:1]};
    assign chunk_base = {chunk_reg, {LOC_W{1'b0}}};
    assign cand_chunk = pivot_cand[chunk_base +: CHUNK_W];
    assign mask_chunk = mask_reg[chunk_base +: CHUNK_W];
    assign found      = |cand_chunk;
    assign loc        = top_bit(cand_chunk);
    assign cnt_add    = found ? pop_chunk(mask_chunk & above_mask(loc)) : pop_chunk(mask_chunk);
    assign cnt_sum    = cnt_reg + CNT_W'(cnt_add);

    // keep bits below the pivot, then pack the pivot and the top run just above it
    assign pivot_ext  = {1'b0, pivot_reg};
    assign mask_next  = (mask_reg & low_mask(pivot_ext))
                      | (low_mask(cnt_reg + CNT_W'(1)) << (pivot_ext + CNT_W'(1)));
    assign last_mask  = full_mask & ~low_mask(n_reg - k_reg);

    assign out_free   = !out_valid_reg || m_tready;

    always_comb begin
        sts             = '0;
        sts.cfg_bad     = (n_reg == '0) || (k_reg == '0) || (k_reg > n_reg)
                       || (n_reg > CNT_W'(MAX_POSITIONS));
        sts.pivot_found = found;
        sts.last_chunk  = (chunk_reg == '0);
        sts.out_free    = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg         <= CNT_W'(64);
            k_reg         <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_TOTAL_COUNT:  n_reg <= cfg_wdata;
                    REG_CHOOSE_COUNT: k_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.resp_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_first) begin
            mask_reg <= low_mask(k_reg);
        end else if (cmd.apply) begin
            mask_reg <= mask_next;
        end
        if (cmd.scan_start) begin
            chunk_reg <= CHUNK_IDX_W'(NUM_CHUNKS - 1);
            cnt_reg   <= '0;
        end else if (cmd.scan_step) begin
            cnt_reg <= cnt_sum;
            if (found) begin
                pivot_reg <= {chunk_reg, loc};
            end else begin
                chunk_reg <= chunk_reg - CHUNK_IDX_W'(1);
            end
        end
        if (cmd.resp_load) begin
            out_status_reg <= cmd.resp_status;
            if (cmd.resp_status == STATUS_OK) begin
                out_mask_reg <= mask_reg;
                out_last_reg <= (mask_reg == last_mask);
            end else begin
                out_mask_reg <= '0;
                out_last_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_mask_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule

// File: rtl/cmbe_ctrl.sv
module cmbe_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              restart,
    input  logic              cfg_we,
    output cmbe_pkg::dp_cmd_t cmd,
    input  cmbe_pkg::dp_sts_t sts
);
    import cmbe_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_RESP
    } state_t;

    state_t  state_reg;
    logic    started_reg;
    logic    exhausted_reg;
    status_t status_reg;
    logic    accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd             = '0;
        cmd.resp_status = status_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !sts.cfg_bad) begin
                    if (restart || !started_reg) begin
                        cmd.load_first = 1'b1;
                    end else if (!exhausted_reg) begin
                        cmd.scan_start = 1'b1;
                    end
                end
            end
            ST_SCAN:  cmd.scan_step = 1'b1;
            ST_APPLY: cmd.apply     = 1'b1;
            ST_RESP:  cmd.resp_load = sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            started_reg   <= 1'b0;
            exhausted_reg <= 1'b0;
            status_reg    <= STATUS_OK;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_RESP;
                        priority if (sts.cfg_bad) begin
                            status_reg <= STATUS_BAD_CONFIG;
                        end else if (restart || !started_reg) begin
                            started_reg   <= 1'b1;
                            exhausted_reg <= 1'b0;
                            status_reg    <= STATUS_OK;
                        end else if (exhausted_reg) begin
                            status_reg <= STATUS_EXHAUSTED;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (sts.pivot_found) begin
                        state_reg <= ST_APPLY;
                    end else if (sts.last_chunk) begin
                        // no slot below its maximum: run is over
                        exhausted_reg <= 1'b1;
                        status_reg    <= STATUS_EXHAUSTED;
                        state_reg     <= ST_RESP;
                    end
                end
                ST_APPLY: begin
                    status_reg <= STATUS_OK;
                    state_reg  <= ST_RESP;
                end
                ST_RESP: begin
                    if (sts.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            // a register write starts the enumeration over
            if (cfg_we) begin
                started_reg   <= 1'b0;
                exhausted_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_exhausted_needs_start: assert property (@(posedge aclk) disable iff (!aresetn)
        exhausted_reg |-> started_reg)
        else $error("exhausted set without a started run");

    a_apply_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY) |-> $past(state_reg == ST_SCAN))
        else $error("apply not preceded by a scan");

    a_cfg_clears_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !started_reg && !exhausted_reg)
        else $error("register write did not restart the enumeration");
`endif

endmodule

// File: rtl/combination_enumerator.sv
// Lexicographic k-of-n subset enumerator.
// Input channel s_*: each request carries one bit, restart (s_tdata[0]). A restart, or
// any request before the first one after reset or a register write, returns the first
// subset {0..k-1}; otherwise the next subset in lexicographic order is returned.
// Output channel m_*: one result per request. m_tdata is the 64-bit subset mask,
// m_tlast marks the final subset, m_tuser is the status (ok, exhausted, bad config).
// Exhausted and bad-config results carry a zero mask and a clear m_tlast.
// Registers are written through cfg_we/cfg_addr/cfg_wdata: index 0 total_count (n),
// index 1 choose_count (k); any write restarts the enumeration.
// Restart, bad-config and already-exhausted requests go from the idle state straight to the
// response state. A next request scans the current mask 16 bits per cycle from the top
// for the pivot, then rebuilds the mask in the apply state before the response state.
// A next request that finds no pivot scans all four 16-bit chunks and returns exhausted.
// One request is in flight at a time; s_tready is high while the controller is idle,
// also while a finished result still waits in the output register.
// If the receiver stalls, the result is held and the next request waits in the
// controller until the output register frees.
// Reset: n = 64, k = 1, no run started, output channel empty.
module combination_enumerator #(
    parameter int MAX_POSITIONS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [0] restart, [7:1] zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cmbe_pkg::MASK_W-1:0]       m_tdata,   // [63:0] subset_mask
    output logic                              m_tlast,   // is_last
    output logic [1:0]                        m_tuser,   // [1:0] status
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [cmbe_pkg::CNT_W-1:0]        cfg_wdata
);
    import cmbe_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    cmbe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .restart  (s_tdata[0]),
        .cfg_we   (cfg_we),
        .cmd      (cmd),
        .sts      (sts)
    );

    cmbe_dp #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// File: test/tb.sv
module tb;
    import cmbe_pkg::*;

    localparam int ITEM_TARGET    = 1800;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              last;
        status_t           status;
    } subset_t;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [MASK_W-1:0] m_tdata;
    logic              m_tlast;
    logic [1:0]        m_tuser;
    logic              cfg_we    = 1'b0;
    logic              cfg_addr  = 1'b0;
    logic [CNT_W-1:0]  cfg_wdata = '0;

    combination_enumerator #(.MAX_POSITIONS(64)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // enumeration state as the block should hold it
    logic [POS_W-1:0] slot_pos [MASK_W];
    bit               run_started   = 1'b0;
    bit               run_exhausted = 1'b0;
    logic [CNT_W-1:0] n_now = CNT_W'(64);
    logic [CNT_W-1:0] k_now = CNT_W'(1);

    bit      restart_flags [$];
    subset_t subset_expect [$];
    subset_t want;
    bit      no_gaps = 1'b0;
    int      send_gap = 0;
    int      recv_gap = 0;
    int      hold_cycles = 0;
    int      results_seen = 0;
    int      mismatch_count = 0;
    int      quiet_cycles = 0;

    function automatic bit config_invalid();
        return n_now == 0 || k_now == 0 || k_now > n_now || n_now > MASK_W;
    endfunction

    // rightmost slot still below its ceiling n-k+i, -1 when on the final subset
    function automatic int find_pivot_slot();
        for (int i = int'(k_now) - 1; i >= 0; i--) begin
            if (int'(slot_pos[i]) != int'(n_now) - int'(k_now) + i) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic subset_t advance_subset(input bit restart);
        subset_t r;
        int p;
        int base;
        r = '0;
        r.status = STATUS_OK;
        if (config_invalid()) begin
            r.status = STATUS_BAD_CONFIG;
            return r;
        end
        if (restart || !run_started) begin
            for (int i = 0; i < int'(k_now); i++) begin
                slot_pos[i] = POS_W'(i);
            end
            run_started = 1'b1;
            run_exhausted = 1'b0;
        end else begin
            if (run_exhausted) begin
                r.status = STATUS_EXHAUSTED;
                return r;
            end
            p = find_pivot_slot();
            if (p < 0) begin
                run_exhausted = 1'b1;
                r.status = STATUS_EXHAUSTED;
                return r;
            end
            base = int'(slot_pos[p]) + 1;
            for (int j = p; j < int'(k_now); j++) begin
                slot_pos[j] = POS_W'(base + j - p);
            end
        end
        for (int i = 0; i < int'(k_now); i++) begin
            r.mask[slot_pos[i]] = 1'b1;
        end
        r.last = (find_pivot_slot() < 0);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                subset_expect = {subset_expect, advance_subset(s_tdata[0])};
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (restart_flags.size() > 0) begin
                    s_tdata  <= {7'b0, restart_flags.pop_front()};
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (subset_expect.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result mask=%h last=%b status=%0d",
                             $time, m_tdata, m_tlast, m_tuser);
                end else begin
                    want = subset_expect.pop_front();
                    if (m_tdata !== want.mask || m_tlast !== want.last ||
                        m_tuser !== want.status) begin
                        mismatch_count++;
                        $display("%0t: mismatch expected mask=%h last=%b status=%0d",
                                 $time, want.mask, want.last, want.status);
                        $display("%0t:          actual   mask=%h last=%b status=%0d",
                                 $time, m_tdata, m_tlast, m_tuser);
                    end
                end
                // long hold-off so the block backs up and drops s_tready
                if (results_seen == 250 || results_seen == 1100) begin
                    hold_cycles = 120;
                end else begin
                    recv_gap = pick_gap();
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (restart_flags.size() != 0 || s_tvalid || subset_expect.size() != 0);
    endtask

    task automatic write_reg(input logic addr, input logic [CNT_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        if (addr == REG_TOTAL_COUNT) begin
            n_now = value;
        end else begin
            k_now = value;
        end
        run_started = 1'b0;
        run_exhausted = 1'b0;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_phase(input int n, input int k);
        wait_idle();
        write_reg(REG_TOTAL_COUNT, CNT_W'(n));
        write_reg(REG_CHOOSE_COUNT, CNT_W'(k));
        @(negedge aclk);
    endtask

    // flags go out lowest bit first
    task automatic push_flags(input int count, input logic [31:0] bits);
        for (int i = 0; i < count; i++) begin
            restart_flags = {restart_flags, bit'(bits[i])};
        end
    endtask

    initial begin
        int nn;
        int kk;
        int len;
        int pick;
        int random_sent;
        random_sent = 0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset counts, next before any start, then restart
        push_flags(4, 32'b0010);
        // single full subset, exhausted, restart
        load_phase(64, 64);
        push_flags(3, 32'b100);
        // walk to the end of 3 choose 2, stay exhausted, restart
        load_phase(3, 2);
        push_flags(6, 32'b100000);
        load_phase(1, 1);
        push_flags(2, 32'b00);
        // bad configurations: n zero, k zero, k above n, n too large, k too large
        load_phase(0, 2);
        push_flags(1, 32'b0);
        load_phase(5, 0);
        push_flags(1, 32'b0);
        load_phase(4, 5);
        push_flags(1, 32'b0);
        load_phase(127, 1);
        push_flags(1, 32'b1);
        load_phase(64, 127);
        push_flags(1, 32'b0);

        while (random_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
                case ($urandom_range(0, 3))
                    0: begin
                        nn = 0;
                        kk = $urandom_range(0, 127);
                    end
                    1: begin
                        nn = $urandom_range(1, 64);
                        kk = 0;
                    end
                    2: begin
                        nn = $urandom_range(1, 63);
                        kk = $urandom_range(nn + 1, 127);
                    end
                    default: begin
                        nn = $urandom_range(65, 127);
                        kk = $urandom_range(1, 127);
                    end
                endcase
                len = $urandom_range(1, 6);
            end else if (pick <= 2) begin
                nn = $urandom_range(11, 64);
                case ($urandom_range(0, 3))
                    0:       kk = 1;
                    1:       kk = nn;
                    2:       kk = nn - 1;
                    default: kk = $urandom_range(1, nn);
                endcase
                len = $urandom_range(20, 90);
            end else begin
                nn = $urandom_range(1, 10);
                kk = $urandom_range(1, nn);
                len = $urandom_range(10, 80);
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            load_phase(nn, kk);
            for (int i = 0; i < len; i++) begin
                restart_flags = {restart_flags, bit'($urandom_range(0, 24) == 0)};
            end
            random_sent += len;
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && subset_expect.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: combination_enumerator.f
rtl/cmbe_pkg.sv
rtl/cmbe_dp.sv
rtl/cmbe_ctrl.sv
rtl/combination_enumerator.sv
test/tb.sv
